FILE: sv/blsu_pkg.sv
`timescale 1ns / 1ps
package blsu_pkg;

  localparam int unsigned MEM_DW_DEFAULT = 1024;
  localparam int unsigned ADDR_W         = 32;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned DWORD_W        = 64;
  // address bits above the byte offset inside a doubleword
  localparam int unsigned DW_ADDR_W      = ADDR_W - 3;
  localparam int unsigned REQ_W          = 4;

  typedef enum logic [REQ_W-1:0] {
    REQ_LB  = 4'd0,
    REQ_LBU = 4'd1,
    REQ_LH  = 4'd2,
    REQ_LHU = 4'd3,
    REQ_LW  = 4'd4,
    REQ_LWL = 4'd5,
    REQ_LWR = 4'd6,
    REQ_SB  = 4'd7,
    REQ_SH  = 4'd8,
    REQ_SW  = 4'd9,
    REQ_SWL = 4'd10,
    REQ_SWR = 4'd11
  } req_e;

  typedef struct packed {
    logic               is_load;
    logic               is_store;
    logic [DATA_W-1:0]  load_data;
    logic [DWORD_W-1:0] wr_data;
  } lane_res_t;

endpackage

FILE: sv/blsu_ram.sv
`timescale 1ns / 1ps
module blsu_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/blsu_index.sv
`timescale 1ns / 1ps
module blsu_index import blsu_pkg::*; #(
  parameter int unsigned Depth = MEM_DW_DEFAULT,
  localparam int unsigned IdxW = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic [DW_ADDR_W-1:0] dw_addr_i,
  output logic [IdxW-1:0]      idx_o
);

  // Reciprocal of Depth scaled by 2^Shift; the quotient estimate is exact or one low.
  localparam int unsigned Shift  = DW_ADDR_W + IdxW;
  localparam int unsigned RecipW = DW_ADDR_W + 1;
  localparam int unsigned MulW   = DW_ADDR_W + RecipW;
  localparam logic [RecipW-1:0] Recip = RecipW'((64'(1) << Shift) / Depth);
  localparam logic [DW_ADDR_W-1:0] DepthX = DW_ADDR_W'(Depth);

  logic [MulW-1:0]      prod_hi_d, prod_hi_q;
  logic [DW_ADDR_W-1:0] quot;
  logic [DW_ADDR_W-1:0] back_d, back_q;
  logic [DW_ADDR_W-1:0] rem, rem_fix;

  assign prod_hi_d = MulW'(dw_addr_i) * MulW'(Recip);
  assign quot      = DW_ADDR_W'(prod_hi_q >> Shift);
  assign back_d    = DW_ADDR_W'(quot * DepthX);

  always_ff @(posedge clk_i) begin
    prod_hi_q <= prod_hi_d;
    back_q    <= back_d;
  end

  // remainder is below twice the depth: one compare and subtract
  assign rem     = dw_addr_i - back_q;
  assign rem_fix = (rem >= DepthX) ? rem - DepthX : rem;
  assign idx_o   = rem_fix[IdxW-1:0];

endmodule

FILE: sv/blsu_lane.sv
`timescale 1ns / 1ps
module blsu_lane import blsu_pkg::*; (
  input  logic [REQ_W-1:0]   req_type_i,
  input  logic [2:0]         offset_i,
  input  logic [DATA_W-1:0]  store_data_i,
  input  logic [DATA_W-1:0]  merge_value_i,
  input  logic [DWORD_W-1:0] dword_i,
  output lane_res_t          res_o
);

  logic [5:0]        byte_sh;
  logic [5:0]        half_sh;
  logic [5:0]        word_sh;
  logic [4:0]        left;
  logic [4:0]        right;
  logic [7:0]        b;
  logic [15:0]       h;
  logic [DATA_W-1:0] w;
  logic [DATA_W-1:0] ones;

  // offset 0 is the most significant byte
  assign byte_sh = {~offset_i, 3'b000};
  assign half_sh = {~offset_i[2:1], 4'b0000};
  assign word_sh = {~offset_i[2], 5'b00000};
  assign left    = {offset_i[1:0], 3'b000};
  assign right   = {~offset_i[1:0], 3'b000};
  assign ones    = '1;

  assign b = dword_i[byte_sh +: 8];
  assign h = dword_i[half_sh +: 16];
  assign w = dword_i[word_sh +: DATA_W];

  always_comb begin
    res_o           = '0;
    res_o.wr_data   = dword_i;
    unique case (req_type_i)
      REQ_LB: begin
        res_o.is_load   = 1'b1;
        res_o.load_data = {{24{b[7]}}, b};
      end
      REQ_LBU: begin
        res_o.is_load   = 1'b1;
        res_o.load_data = {24'd0, b};
      end
      REQ_LH: begin
        res_o.is_load   = 1'b1;
        res_o.load_data = {{16{h[15]}}, h};
      end
      REQ_LHU: begin
        res_o.is_load   = 1'b1;
        res_o.load_data = {16'd0, h};
      end
      REQ_LW: begin
        res_o.is_load   = 1'b1;
        res_o.load_data = w;
      end
      REQ_LWL: begin
        res_o.is_load   = 1'b1;
        res_o.load_data = (w << left) | (merge_value_i & ~(ones << left));
      end
      REQ_LWR: begin
        res_o.is_load   = 1'b1;
        res_o.load_data = (w >> right) | (merge_value_i & ~(ones >> right));
      end
      REQ_SB: begin
        res_o.is_store              = 1'b1;
        res_o.wr_data[byte_sh +: 8] = store_data_i[7:0];
      end
      REQ_SH: begin
        res_o.is_store               = 1'b1;
        res_o.wr_data[half_sh +: 16] = store_data_i[15:0];
      end
      REQ_SW: begin
        res_o.is_store                   = 1'b1;
        res_o.wr_data[word_sh +: DATA_W] = store_data_i;
      end
      REQ_SWL: begin
        res_o.is_store                   = 1'b1;
        res_o.wr_data[word_sh +: DATA_W] = (store_data_i >> left) | (w & ~(ones >> left));
      end
      REQ_SWR: begin
        res_o.is_store                   = 1'b1;
        res_o.wr_data[word_sh +: DATA_W] = (store_data_i << right) | (w & ~(ones << right));
      end
      default: begin
        // undefined request codes: no result, memory untouched
        res_o.is_load  = 1'b0;
        res_o.is_store = 1'b0;
      end
    endcase
  end

endmodule

FILE: sv/big_endian_load_store_unit.sv
`timescale 1ns / 1ps
// Big-endian load/store memory stage over a store of MEM_DOUBLEWORDS 64-bit
// doublewords, all zero after reset. Each beat on the slave side is one access;
// the doubleword used is (address >> 3) modulo MEM_DOUBLEWORDS, byte offset 0
// is its most significant byte, and address bits below the access size are
// ignored (no alignment trap). Loads (lb, lbu, lh, lhu, lw, lwl, lwr) return
// one beat on the master side; stores (sb, sh, sw, swl, swr) return nothing and
// update the doubleword by read-modify-write; the undefined codes 12..15
// neither load nor store and leave the memory untouched. After reset the block
// sweeps every doubleword of the memory with zeros and holds
// s_axis_tready low meanwhile.
// Each access then passes through the states IDLE (accept), MUL1 and MUL2 (the
// reciprocal multiply that folds the address onto the depth), READ (the
// synchronous memory read) and EXEC (extract the lane or write back).
// Only one access is in flight, so a load always sees every earlier store.
// A finished load waits in the output register while the next beat is
// accepted; the execute cycle holds only if that register is still full.
module big_endian_load_store_unit import blsu_pkg::*; #(
  parameter int unsigned MEM_DOUBLEWORDS = MEM_DW_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // tuser: [3:0] req_type
  input  logic [3:0]    s_axis_tuser,
  // tdata: [31:0] address, [63:32] store_data, [95:64] merge_value
  input  logic [95:0]   s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // tdata: [31:0] load_data
  output logic [31:0]   m_axis_tdata
);

  localparam int unsigned IdxW = $clog2(MEM_DOUBLEWORDS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MEM_DOUBLEWORDS - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MUL1  = 3'd2;
  localparam logic [2:0] ST_MUL2  = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_EXEC  = 3'd5;

  logic [2:0]         state_d, state_q;
  logic [IdxW-1:0]    clr_cnt_d, clr_cnt_q;

  // captured access
  logic [REQ_W-1:0]   req_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [DATA_W-1:0]  sdata_q;
  logic [DATA_W-1:0]  merge_q;

  logic               out_valid_d, out_valid_q;
  logic [DATA_W-1:0]  out_data_d, out_data_q;

  logic [IdxW-1:0]    idx;
  logic [DWORD_W-1:0] rd_dword;
  lane_res_t          lane;

  logic               ram_we;
  logic [IdxW-1:0]    ram_waddr;
  logic [DWORD_W-1:0] ram_wdata;

  logic               in_fire;
  logic               out_free;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // fold the doubleword address onto the memory depth
  blsu_index #(
    .Depth (MEM_DOUBLEWORDS)
  ) u_index (
    .clk_i     (clk_i),
    .dw_addr_i (addr_q[ADDR_W-1:3]),
    .idx_o     (idx)
  );

  blsu_ram #(
    .Width (DWORD_W),
    .Depth (MEM_DOUBLEWORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (state_q == ST_READ),
    .raddr_i (idx),
    .rdata_o (rd_dword)
  );

  blsu_lane u_lane (
    .req_type_i    (req_q),
    .offset_i      (addr_q[2:0]),
    .store_data_i  (sdata_q),
    .merge_value_i (merge_q),
    .dword_i       (rd_dword),
    .res_o         (lane)
  );

  // write port: zero sweep after reset, otherwise the merged doubleword
  always_comb begin
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else begin
      ram_we    = (state_q == ST_EXEC) && lane.is_store;
      ram_waddr = idx;
      ram_wdata = lane.wr_data;
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == LastIdx) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_READ;
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: begin
        if (!lane.is_load) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          // hold here while the previous load beat is still waiting
          out_valid_d = 1'b1;
          out_data_d  = lane.load_data;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (in_fire) begin
      req_q   <= s_axis_tuser;
      addr_q  <= s_axis_tdata[31:0];
      sdata_q <= s_axis_tdata[63:32];
      merge_q <= s_axis_tdata[95:64];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

FILE: tb/big_endian_load_store_unit_test.sv
`timescale 1ns / 1ps
module big_endian_load_store_unit_test;
  import blsu_pkg::*;

  localparam int unsigned MEM_DW = MEM_DW_DEFAULT;
  localparam int unsigned RANDOM_ACCESSES = 800;
  // Stop idling on both sides for the last stretch of random beats.
  localparam int unsigned CALM_FROM = 700;
  localparam int unsigned DRAIN_CYCLES = 12;

  // Request codes past the defined set: no memory change, no load beat.
  localparam logic [REQ_W-1:0] REQ_RSVD_LO = 4'd12;
  localparam logic [REQ_W-1:0] REQ_RSVD_HI = 4'd15;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // tuser: [3:0] req_type
  logic [3:0]  s_axis_tuser;
  // tdata: [31:0] address, [63:32] store_data, [95:64] merge_value
  logic [95:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // tdata: [31:0] load_data
  logic [31:0] m_axis_tdata;

  big_endian_load_store_unit #(
    .MEM_DOUBLEWORDS(MEM_DW)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // One directed access; a load row may carry a hand-typed expected value.
  typedef struct {
    logic [REQ_W-1:0]  req;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] sdata;
    logic [DATA_W-1:0] merge;
    bit                fixed;
    logic [DATA_W-1:0] value;
  } access_row_t;

  localparam int unsigned ROWS = 24;

  access_row_t       plan [ROWS];
  logic [DWORD_W-1:0] shadow_dw [MEM_DW];
  logic [DATA_W-1:0] expected_loads [$];
  logic [DATA_W-1:0] want_data;
  int unsigned       mismatches;
  int unsigned       send_gap_odds;
  int unsigned       stall_odds;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Abort a hung run; a correct one finishes far sooner.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [DWORD_W-1:0] put_lane(input logic [DWORD_W-1:0] dw,
                                                  input int unsigned sh,
                                                  input logic [DWORD_W-1:0] mask,
                                                  input logic [DATA_W-1:0] val);
    return (dw & ~(mask << sh)) | (({32'd0, val} & mask) << sh);
  endfunction

  // Apply one access to the shadow memory; return 1 and the load value for loads.
  function automatic bit model_access(input logic [REQ_W-1:0] req,
                                      input logic [ADDR_W-1:0] addr,
                                      input logic [DATA_W-1:0] sdata,
                                      input logic [DATA_W-1:0] merge,
                                      output logic [DATA_W-1:0] data);
    int unsigned       idx;
    int unsigned       bsh;
    int unsigned       hsh;
    int unsigned       wsh;
    int unsigned       left;
    int unsigned       right;
    logic [DWORD_W-1:0] dw;
    logic [7:0]        b;
    logic [15:0]       h;
    logic [DATA_W-1:0] w;
    idx   = (addr >> 3) % MEM_DW;
    dw    = shadow_dw[idx];
    // Byte offset 0 is the most significant byte of the doubleword.
    bsh   = (7 - addr[2:0]) * 8;
    hsh   = (3 - addr[2:1]) * 16;
    wsh   = (1 - addr[2]) * 32;
    left  = addr[1:0] * 8;
    right = (3 - addr[1:0]) * 8;
    b     = dw[bsh +: 8];
    h     = dw[hsh +: 16];
    w     = dw[wsh +: 32];
    data  = '0;
    case (req)
      REQ_LB:  data = {{24{b[7]}}, b};
      REQ_LBU: data = {24'd0, b};
      REQ_LH:  data = {{16{h[15]}}, h};
      REQ_LHU: data = {16'd0, h};
      REQ_LW:  data = w;
      REQ_LWL: data = (w << left) | (merge & ~(32'hFFFF_FFFF << left));
      REQ_LWR: data = (w >> right) | (merge & ~(32'hFFFF_FFFF >> right));
      REQ_SB:  shadow_dw[idx] = put_lane(dw, bsh, 64'hFF, sdata);
      REQ_SH:  shadow_dw[idx] = put_lane(dw, hsh, 64'hFFFF, sdata);
      REQ_SW:  shadow_dw[idx] = put_lane(dw, wsh, 64'hFFFF_FFFF, sdata);
      REQ_SWL: begin
        w = (sdata >> left) | (w & ~(32'hFFFF_FFFF >> left));
        shadow_dw[idx] = put_lane(dw, wsh, 64'hFFFF_FFFF, w);
      end
      REQ_SWR: begin
        w = (sdata << right) | (w & ~(32'hFFFF_FFFF << right));
        shadow_dw[idx] = put_lane(dw, wsh, 64'hFFFF_FFFF, w);
      end
      default: ;
    endcase
    return req inside {[REQ_LB:REQ_LWR]};
  endfunction

  // Drive one beat on the slave side, hold it until accepted, then predict.
  task automatic send_access(input logic [REQ_W-1:0] req, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] sdata,
                             input logic [DATA_W-1:0] merge,
                             input bit fixed, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] predicted;
    // Insert an idle burst now and then; the lowering and raising of tvalid
    // land on different falling edges.
    if (send_gap_odds != 0 && $urandom_range(1, send_gap_odds) == 1) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {merge, sdata, addr};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    // Beat accepted at this edge: queue its load value, if any.
    if (model_access(req, addr, sdata, merge, predicted))
      expected_loads.push_back(fixed ? value : predicted);
    @(negedge clk_i);
  endtask

  // Concentrate addresses on a few doublewords at both ends of the store, with
  // random upper bits so that aliased addresses hit the same entry; leave a
  // quarter of them fully random.
  function automatic logic [ADDR_W-1:0] pick_address();
    logic [ADDR_W-1:0] a;
    int unsigned       hot;
    a = $urandom;
    if ($urandom_range(0, 3) != 0) begin
      hot = $urandom_range(0, 7);
      hot = (hot < 4) ? hot : MEM_DW - 8 + hot;
      a   = a - ((a >> 3) % MEM_DW) * 8 + hot * 8;
    end
    return a;
  endfunction

  function automatic logic [REQ_W-1:0] pick_request();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4)
      return REQ_W'($urandom_range(REQ_SB, REQ_SWR));
    if (r < 9)
      return REQ_W'($urandom_range(REQ_LB, REQ_LWR));
    return REQ_W'($urandom_range(REQ_RSVD_LO, REQ_RSVD_HI));
  endfunction

  // Receiver: stall the master side in random bursts while stall_odds allows.
  always begin
    @(negedge clk_i);
    if (rst_ni && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    m_axis_tready <= 1'b1;
  end

  // Checker: compare every load beat with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_loads.size() == 0) begin
        $error("load_data: no load pending, actual %h", m_axis_tdata);
        mismatches++;
      end else begin
        want_data = expected_loads.pop_front();
        if (m_axis_tdata !== want_data) begin
          $error("load_data: expected %h, actual %h", want_data, m_axis_tdata);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = '0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    mismatches    = 0;
    send_gap_odds = 0;
    stall_odds    = 0;
    for (int i = 0; i < MEM_DW; i++) shadow_dw[i] = '0;

    // Directed accesses: empty store, all-ones word, several lanes of every width,
    // misaligned halfwords and words, partial-word merges, index wrap past the
    // end of the store, and the undefined request codes.
    plan = '{
      '{REQ_LW,      32'h0000_0000, 32'h0,         32'h0,         1'b1, 32'h0},
      '{REQ_LB,      32'hFFFF_FFFF, 32'h0,         32'hFFFF_FFFF, 1'b1, 32'h0},
      '{REQ_SW,      32'h0000_0000, 32'hFFFF_FFFF, 32'h0,         1'b0, 32'h0},
      '{REQ_LB,      32'h0000_0000, 32'h0,         32'h0,         1'b1, 32'hFFFF_FFFF},
      '{REQ_LBU,     32'h0000_0001, 32'h0,         32'h0,         1'b1, 32'h0000_00FF},
      '{REQ_LH,      32'h0000_0002, 32'h0,         32'h0,         1'b1, 32'hFFFF_FFFF},
      '{REQ_LHU,     32'h0000_0003, 32'h0,         32'h0,         1'b1, 32'h0000_FFFF},
      '{REQ_LW,      32'h0000_0004, 32'h0,         32'h0,         1'b1, 32'h0},
      '{REQ_SB,      32'h0000_0005, 32'h1234_5680, 32'h0,         1'b0, 32'h0},
      '{REQ_SH,      32'h0000_0006, 32'h0000_A5A5, 32'h0,         1'b0, 32'h0},
      '{REQ_LW,      32'h0000_0007, 32'h0,         32'h0,         1'b0, 32'h0},
      '{REQ_SWL,     32'h0000_0001, 32'h1122_3344, 32'h0,         1'b0, 32'h0},
      '{REQ_SWR,     32'h0000_0002, 32'h5566_7788, 32'h0,         1'b0, 32'h0},
      '{REQ_LWL,     32'h0000_0003, 32'h0,         32'hDEAD_BEEF, 1'b0, 32'h0},
      '{REQ_LWR,     32'h0000_0001, 32'h0,         32'hCAFE_F00D, 1'b0, 32'h0},
      '{REQ_SW,      32'h0000_2000, 32'h0BAD_C0DE, 32'h0,         1'b0, 32'h0},
      '{REQ_LW,      32'h0000_0000, 32'h0,         32'h0,         1'b0, 32'h0},
      '{REQ_SW,      32'hFFFF_FFFC, 32'h8000_0001, 32'h0,         1'b0, 32'h0},
      '{REQ_LWL,     32'hFFFF_FFFF, 32'h0,         32'hFFFF_FFFF, 1'b0, 32'h0},
      '{REQ_LWR,     32'hFFFF_FFFC, 32'h0,         32'h0,         1'b0, 32'h0},
      '{REQ_RSVD_LO, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{REQ_RSVD_HI, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{REQ_LW,      32'h0000_0000, 32'h0,         32'h0,         1'b0, 32'h0},
      '{REQ_LHU,     32'hFFFF_FFFE, 32'h0,         32'h0,         1'b0, 32'h0}
    };

    // Hold reset, release at a falling edge.
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Run the directed part at full rate on both sides.
    foreach (plan[i])
      send_access(plan[i].req, plan[i].addr, plan[i].sdata, plan[i].merge,
                  plan[i].fixed, plan[i].value);

    // Random part: change the idling mix every 50 beats, quiet at the end.
    for (int unsigned n = 0; n < RANDOM_ACCESSES; n++) begin
      if (n % 50 == 0) begin
        send_gap_odds = (n >= CALM_FROM) ? 0 : $urandom_range(0, 1) * $urandom_range(2, 8);
        stall_odds    = (n >= CALM_FROM) ? 0 : $urandom_range(0, 1) * $urandom_range(2, 8);
      end
      send_access(pick_request(), pick_address(), $urandom, $urandom, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    // Drain outstanding loads, then give the pipeline time to misbehave.
    while (expected_loads.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
